// File: rtl/mebe_pkg.sv
package mebe_pkg;

   // request beat layout
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned DELTA_LSB  = 0;
   localparam int unsigned CHAN_LSB   = 32;
   localparam int unsigned KIND_LSB   = 36;
   localparam int unsigned DATA1_LSB  = 38;
   localparam int unsigned DATA2_LSB  = 46;
   localparam int unsigned MKIND_LSB  = 54;
   localparam int unsigned PLEN_LSB   = 62;
   localparam int unsigned PBYTE_LSB  = 94;

   typedef logic [1:0] action_type;
   localparam action_type ACT_CHANNEL   = 2'd0;
   localparam action_type ACT_META_HDR  = 2'd1;
   localparam action_type ACT_META_BYTE = 2'd2;
   localparam action_type ACT_UNUSED    = 2'd3;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_CTRL_CHANGE = 2'd0;
   localparam kind_type KIND_NOTE_OFF    = 2'd1;
   localparam kind_type KIND_NOTE_ON     = 2'd2;
   localparam kind_type KIND_PROGRAM     = 2'd3;

   // status nibble per message kind
   localparam logic [7:0] STATUS_CTRL_CHANGE = 8'hB0;
   localparam logic [7:0] STATUS_NOTE_OFF    = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON     = 8'h90;
   localparam logic [7:0] STATUS_PROGRAM     = 8'hC0;

   localparam logic [7:0] META_STATUS = 8'hFF;

   // output byte sources
   typedef logic [2:0] src_type;
   localparam src_type SRC_VLQ       = 3'd0;
   localparam src_type SRC_STATUS    = 3'd1;
   localparam src_type SRC_DATA1     = 3'd2;
   localparam src_type SRC_DATA2     = 3'd3;
   localparam src_type SRC_META_FF   = 3'd4;
   localparam src_type SRC_META_KIND = 3'd5;
   localparam src_type SRC_PAYLOAD   = 3'd6;

   typedef struct packed {
      logic    load;      // capture request beat
      logic    emit;      // write a byte to the output register
      logic    last;      // byte closes the item
      src_type src;
      logic    vlq_plen;  // switch VLQ unit to payload length
      logic    vlq_dec;   // step to next lower 7-bit group
   } cmd_type;

   typedef struct packed {
      action_type req_action;
      action_type action;
      kind_type   kind;
      logic       status_new;  // status byte differs from the remembered one
      logic       vlq_last;    // current group is the lowest
      logic       out_free;    // output register can take a byte
   } stat_type;

endpackage

// File: rtl/mebe_ctrl.sv
module mebe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  mebe_pkg::stat_type stat,
   output mebe_pkg::cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DELTA     = 4'd1;
   localparam logic [3:0] ST_STATUS    = 4'd2;
   localparam logic [3:0] ST_DATA1     = 4'd3;
   localparam logic [3:0] ST_DATA2     = 4'd4;
   localparam logic [3:0] ST_META_FF   = 4'd5;
   localparam logic [3:0] ST_META_KIND = 4'd6;
   localparam logic [3:0] ST_PLEN      = 4'd7;
   localparam logic [3:0] ST_PAYLOAD   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.src      = mebe_pkg::SRC_VLQ;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (stat.req_action) inside
                  mebe_pkg::ACT_CHANNEL, mebe_pkg::ACT_META_HDR: state_in = ST_DELTA;
                  mebe_pkg::ACT_META_BYTE: state_in = ST_PAYLOAD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DELTA: begin
            cmd.src = mebe_pkg::SRC_VLQ;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (!stat.vlq_last) begin
                  cmd.vlq_dec = 1'b1;
               end else if (stat.action == mebe_pkg::ACT_META_HDR) begin
                  state_in = ST_META_FF;
               end else if (stat.status_new) begin
                  state_in = ST_STATUS;
               end else begin
                  state_in = ST_DATA1;
               end
            end
         end
         ST_STATUS: begin
            cmd.src = mebe_pkg::SRC_STATUS;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_DATA1;
            end
         end
         ST_DATA1: begin
            cmd.src  = mebe_pkg::SRC_DATA1;
            cmd.last = (stat.kind == mebe_pkg::KIND_PROGRAM);
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = cmd.last ? ST_IDLE : ST_DATA2;
            end
         end
         ST_DATA2: begin
            cmd.src  = mebe_pkg::SRC_DATA2;
            cmd.last = 1'b1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_META_FF: begin
            cmd.src = mebe_pkg::SRC_META_FF;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_META_KIND;
            end
         end
         ST_META_KIND: begin
            cmd.src = mebe_pkg::SRC_META_KIND;
            if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.vlq_plen = 1'b1;
               state_in     = ST_PLEN;
            end
         end
         ST_PLEN: begin
            cmd.src  = mebe_pkg::SRC_VLQ;
            cmd.last = stat.vlq_last;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.vlq_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.vlq_dec = 1'b1;
               end
            end
         end
         ST_PAYLOAD: begin
            cmd.src  = mebe_pkg::SRC_PAYLOAD;
            cmd.last = 1'b1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/mebe_dpath.sv
module mebe_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mebe_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  mebe_pkg::action_type                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,
   output logic                                rsp_tlast,
   input  mebe_pkg::cmd_type                   cmd,
   output mebe_pkg::stat_type                  stat
);

   // highest nonzero 7-bit group of a 32-bit value
   function automatic logic [2:0] vlq_top(input logic [31:0] v);
      logic [2:0] g;
      if (v[31:28] != 4'd0)      g = 3'd4;
      else if (v[27:21] != 7'd0) g = 3'd3;
      else if (v[20:14] != 7'd0) g = 3'd2;
      else if (v[13:7] != 7'd0)  g = 3'd1;
      else                       g = 3'd0;
      return g;
   endfunction

   function automatic logic [7:0] kind_status(input mebe_pkg::kind_type k);
      logic [7:0] s;
      case (k)
         mebe_pkg::KIND_CTRL_CHANGE: s = mebe_pkg::STATUS_CTRL_CHANGE;
         mebe_pkg::KIND_NOTE_OFF:    s = mebe_pkg::STATUS_NOTE_OFF;
         mebe_pkg::KIND_NOTE_ON:     s = mebe_pkg::STATUS_NOTE_ON;
         default:                    s = mebe_pkg::STATUS_PROGRAM;
      endcase
      return s;
   endfunction

   logic [31:0]          in_delta, in_plen;
   logic [3:0]           in_chan;
   mebe_pkg::kind_type   in_kind;
   logic [7:0]           in_status;

   logic [31:0]          delta_ff, plen_ff;
   logic [7:0]           data1_ff, data2_ff, mkind_ff, pbyte_ff, status_ff;
   mebe_pkg::action_type action_ff;
   mebe_pkg::kind_type   kind_ff;
   logic                 status_new_ff;
   logic [7:0]           remembered_ff;
   logic [2:0]           grp_ff;
   logic                 vlq_plen_ff;
   logic                 valid_ff;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff;

   logic [31:0]          vlq_val;
   logic [6:0]           vlq_bits;

   assign in_delta  = req_tdata[mebe_pkg::DELTA_LSB +: 32];
   assign in_plen   = req_tdata[mebe_pkg::PLEN_LSB +: 32];
   assign in_chan   = req_tdata[mebe_pkg::CHAN_LSB +: 4];
   assign in_kind   = req_tdata[mebe_pkg::KIND_LSB +: 2];
   assign in_status = kind_status(in_kind) | {4'd0, in_chan};

   assign vlq_val = vlq_plen_ff ? plen_ff : delta_ff;
   always_comb begin
      case (grp_ff)
         3'd0:    vlq_bits = vlq_val[6:0];
         3'd1:    vlq_bits = vlq_val[13:7];
         3'd2:    vlq_bits = vlq_val[20:14];
         3'd3:    vlq_bits = vlq_val[27:21];
         default: vlq_bits = {3'd0, vlq_val[31:28]};
      endcase
   end

   always_comb begin
      case (cmd.src)
         mebe_pkg::SRC_VLQ:       byte_in = {(grp_ff != 3'd0), vlq_bits};
         mebe_pkg::SRC_STATUS:    byte_in = status_ff;
         mebe_pkg::SRC_DATA1:     byte_in = data1_ff;
         mebe_pkg::SRC_DATA2:     byte_in = data2_ff;
         mebe_pkg::SRC_META_FF:   byte_in = mebe_pkg::META_STATUS;
         mebe_pkg::SRC_META_KIND: byte_in = mkind_ff;
         default:                 byte_in = pbyte_ff;
      endcase
   end

   // captured fields, VLQ group counter and output byte register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         delta_ff      <= in_delta;
         plen_ff       <= in_plen;
         data1_ff      <= req_tdata[mebe_pkg::DATA1_LSB +: 8];
         data2_ff      <= req_tdata[mebe_pkg::DATA2_LSB +: 8];
         mkind_ff      <= req_tdata[mebe_pkg::MKIND_LSB +: 8];
         pbyte_ff      <= req_tdata[mebe_pkg::PBYTE_LSB +: 8];
         status_ff     <= in_status;
         status_new_ff <= (in_status != remembered_ff);
         action_ff     <= req_tuser;
         kind_ff       <= in_kind;
         grp_ff        <= vlq_top(in_delta);
         vlq_plen_ff   <= 1'b0;
      end else if (cmd.vlq_plen) begin
         grp_ff        <= vlq_top(plen_ff);
         vlq_plen_ff   <= 1'b1;
      end else if (cmd.vlq_dec) begin
         grp_ff        <= grp_ff - 3'd1;
      end
      if (cmd.emit) begin
         byte_ff <= byte_in;
         last_ff <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remembered_ff <= 8'd0;
         valid_ff      <= 1'b0;
      end else begin
         if (cmd.load && req_tuser == mebe_pkg::ACT_CHANNEL) begin
            remembered_ff <= in_status;
         end else if (cmd.load && req_tuser == mebe_pkg::ACT_META_HDR) begin
            remembered_ff <= mebe_pkg::META_STATUS;
         end
         if (cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

   assign stat.req_action = req_tuser;
   assign stat.action     = action_ff;
   assign stat.kind       = kind_ff;
   assign stat.status_new = status_new_ff;
   assign stat.vlq_last   = (grp_ff == 3'd0);
   assign stat.out_free   = !valid_ff || rsp_tready;

endmodule

// File: rtl/midi_event_byte_encoder.sv
// MIDI file event encoder: each request beat (a channel message, a meta
// event header or one meta payload byte) becomes a run of byte beats on the
// response side, the last one flagged with rsp_tlast. A channel message
// sends its delta time as a VLQ, the status byte only when it differs from
// the last status sent (running status, reset value 0), then one or two data
// bytes; a meta header sends the delta VLQ, 0xFF, the meta type and the
// payload length VLQ, and sets the remembered status to 0xFF. Action code 3
// produces no beat. While the output register is free, the sequencer emits
// one byte per cycle into that single output register. An item has 2 to 8
// bytes for a channel message, 4 to 12 for a meta header and 1 for a
// payload byte, and each request is captured before its first byte. The next
// request is taken once the last byte of the current item has been written
// to the output register, even while that byte still waits to be taken.
module midi_event_byte_encoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // low to high: delta_time[31:0], channel_number[35:32], message_kind[37:36],
   // first_data[45:38], second_data[53:46], meta_kind[61:54],
   // payload_length[93:62], payload_byte[101:94], zero pad[103:102]
   input  logic [103:0] req_tdata,
   // action: 0 channel message, 1 meta header, 2 meta payload byte
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_byte[7:0]
   output logic [7:0]   rsp_tdata,
   // run_end: last byte of the item
   output logic         rsp_tlast
);

   mebe_pkg::cmd_type  cmd;
   mebe_pkg::stat_type stat;

   // sequencer: walks delta VLQ, status, data / meta fields, length VLQ
   mebe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // field capture, running status, VLQ group select, output register
   mebe_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

   // a non-final byte in the output register means the item is still running
   a_busy_mid_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken while an item is still being encoded");

   // unused action code produces nothing and leaves the encoder ready
   a_unused_action: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == mebe_pkg::ACT_UNUSED |=> req_tready)
      else $error("unused action did not return to idle");

   // multi-byte items hold off the next request in the cycle after they are taken
   a_multi_byte_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == mebe_pkg::ACT_CHANNEL || req_tuser == mebe_pkg::ACT_META_HDR)
      |=> !req_tready)
      else $error("encoder ready right after taking a multi-byte item");

endmodule
